// ===== hw/rtl/assert_macros.svh =====
// Assertion macros included by the converter's top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/qte_pkg.sv =====
// Widths, codes, types and CORDIC constants of the quaternion to Euler angle converter
package qte_pkg;

  localparam int COMP_W_DEF = 16;
  localparam int STEPS_DEF  = 16;

  localparam int Q_W    = 16;
  localparam int PROD_W = 32;
  localparam int UNIT_W = 33;
  localparam int ARG_W  = 34;
  localparam int THR_W  = 16;
  localparam int CMP_W  = 50;

  localparam int DIV_BITS   = 30;
  localparam int REM_W      = 34;
  localparam int S_W        = 32;
  localparam int C_W        = 31;
  localparam int SQ_W       = 62;
  localparam int SQRT_STEPS = 31;
  localparam int ASIN_LAT   = DIV_BITS + SQRT_STEPS + 4;

  localparam int NORM_STEPS = 6;
  localparam int CIN_W      = 42;
  localparam int CX_W       = 44;
  localparam int ZW         = 34;

  localparam int ANG_W     = 16;
  localparam int EXT_W     = 36;
  localparam int Q13_SHIFT = 17;
  localparam int Q13_HALF  = 65536;
  localparam int ANG_MAX   = 32767;
  localparam int ANG_MIN   = -32768;

  localparam logic signed [ZW-1:0]    PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0]    HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 16'sd12868;

  localparam logic [1:0] POLE_NONE  = 2'd0;
  localparam logic [1:0] POLE_NORTH = 2'd1;
  localparam logic [1:0] POLE_SOUTH = 2'd2;

  localparam int              CFG_ADDR_W   = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_POLE_THR = 3'd0;
  localparam logic [THR_W-1:0] THR_RESET    = 16'd32735;

  typedef struct packed {
    logic [1:0]              pole;
    logic                    zero;
    logic signed [Q_W-1:0]   qx;
    logic signed [Q_W-1:0]   qy;
    logic signed [ARG_W-1:0] yn;
    logic signed [ARG_W-1:0] yd;
    logic signed [ARG_W-1:0] zn;
    logic signed [ARG_W-1:0] zd;
  } side_t;

  typedef struct packed {
    logic [1:0] pole;
    logic       zero;
  } tail_t;

  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:       r = 34'sd843314857;
      1:       r = 34'sd497837829;
      2:       r = 34'sd263043837;
      3:       r = 34'sd133525159;
      4:       r = 34'sd67021687;
      5:       r = 34'sd33543516;
      6:       r = 34'sd16775851;
      7:       r = 34'sd8388437;
      8:       r = 34'sd4194283;
      9:       r = 34'sd2097149;
      10:      r = 34'sd1048576;
      default: r = (i <= 30) ? (ZW'(1) <<< (30 - i)) : '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/qte_asin_arg.sv =====
// Pipelined restoring divider and square root forming the arcsine CORDIC arguments
module qte_asin_arg
  import qte_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [ARG_W-1:0]  num_i,
  input  logic        [UNIT_W-1:0] den_i,
  output logic signed [S_W-1:0]    sin_o,
  output logic        [C_W-1:0]    cos_o
);

  localparam int ROOT_TOP = 2 * (SQRT_STEPS - 1);

  typedef struct packed {
    logic                neg;
    logic                ovf;
    logic [REM_W-1:0]    rem;
    logic [UNIT_W-1:0]   den;
    logic [DIV_BITS-1:0] quo;
  } div_t;

  typedef struct packed {
    logic signed [S_W-1:0] s;
    logic [SQ_W-1:0]       rad;
    logic [SQ_W-1:0]       res;
  } root_t;

  div_t  div_q  [DIV_BITS+1];
  root_t root_q [SQRT_STEPS+1];

  logic [REM_W-1:0] mag;
  logic [C_W-1:0]   q_mag;
  logic [C_W-1:0]   ms_q;
  logic signed [S_W-1:0] s1_q;
  logic signed [S_W-1:0] s2_q;
  logic [SQ_W-1:0]  sq_q;

  assign mag = num_i[ARG_W-1] ? REM_W'(-num_i) : REM_W'(num_i);

  always_ff @(posedge clk_i) begin
    div_q[0] <= '{neg: num_i[ARG_W-1], ovf: (mag >= REM_W'(den_i)), rem: mag,
                  den: den_i, quo: '0};
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    logic [REM_W-1:0] dbl;
    logic             ge;
    assign dbl = {div_q[k].rem[REM_W-2:0], 1'b0};
    assign ge  = dbl >= REM_W'(div_q[k].den);
    always_ff @(posedge clk_i) begin
      div_q[k+1] <= '{neg: div_q[k].neg, ovf: div_q[k].ovf,
                      rem: (ge ? dbl - REM_W'(div_q[k].den) : dbl),
                      den: div_q[k].den, quo: {div_q[k].quo[DIV_BITS-2:0], ge}};
    end
  end

  // clamp the quotient to one
  assign q_mag = div_q[DIV_BITS].ovf ? (C_W'(1) << DIV_BITS) : {1'b0, div_q[DIV_BITS].quo};

  always_ff @(posedge clk_i) begin
    ms_q <= q_mag;
    s1_q <= div_q[DIV_BITS].neg ? -$signed(S_W'(q_mag)) : $signed(S_W'(q_mag));
    sq_q <= SQ_W'(ms_q) * SQ_W'(ms_q);
    s2_q <= s1_q;
    root_q[0] <= '{s: s2_q, rad: ((SQ_W'(1) << ROOT_TOP) - sq_q), res: '0};
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_root
    localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (ROOT_TOP - 2 * j);
    logic [SQ_W-1:0] trial;
    logic            take;
    assign trial = root_q[j].res + BITV;
    assign take  = root_q[j].rad >= trial;
    always_ff @(posedge clk_i) begin
      root_q[j+1] <= '{s: root_q[j].s,
                       rad: (take ? root_q[j].rad - trial : root_q[j].rad),
                       res: (take ? (root_q[j].res >> 1) + BITV : root_q[j].res >> 1)};
    end
  end

  assign sin_o = root_q[SQRT_STEPS].s;
  assign cos_o = root_q[SQRT_STEPS].res[C_W-1:0];

endmodule

// ===== hw/rtl/qte_cordic.sv =====
// Pipelined atan2: quadrant fold, staged normalising shift and vectoring CORDIC
module qte_cordic
  import qte_pkg::*;
#(
  parameter int STEPS = STEPS_DEF
)(
  input  logic                    clk_i,
  input  logic signed [CIN_W-1:0] y_i,
  input  logic signed [CIN_W-1:0] x_i,
  output logic signed [ZW-1:0]    z_o
);

  typedef struct packed {
    logic                    zero;
    logic signed [CIN_W-1:0] x;
    logic signed [CIN_W-1:0] y;
    logic [CIN_W-2:0]        m;
    logic signed [ZW-1:0]    z;
  } nrm_t;

  typedef struct packed {
    logic                   zero;
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [ZW-1:0]   z;
  } rot_t;

  nrm_t nrm_q [NORM_STEPS+1];
  rot_t rot_q [STEPS+1];
  nrm_t nrm_d;

  logic [CIN_W-1:0] ax;
  logic [CIN_W-1:0] ay;

  assign ax = x_i[CIN_W-1] ? CIN_W'(-x_i) : CIN_W'(x_i);
  assign ay = y_i[CIN_W-1] ? CIN_W'(-y_i) : CIN_W'(y_i);

  always_comb begin
    nrm_d.zero = (x_i == '0) && (y_i == '0);
    nrm_d.x    = x_i[CIN_W-1] ? -x_i : x_i;
    nrm_d.y    = x_i[CIN_W-1] ? -y_i : y_i;
    nrm_d.m    = (ax > ay) ? ax[CIN_W-2:0] : ay[CIN_W-2:0];
    nrm_d.z    = '0;
    if (x_i[CIN_W-1]) begin
      nrm_d.z = y_i[CIN_W-1] ? -PI_Q30 : PI_Q30;
    end
  end

  always_ff @(posedge clk_i) begin
    nrm_q[0] <= nrm_d;
  end

  // shift left until the larger magnitude reaches the top bit
  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam int SH = 1 << (NORM_STEPS - 1 - k);
    logic shift;
    assign shift = nrm_q[k].m[CIN_W-2 -: SH] == '0;
    always_ff @(posedge clk_i) begin
      nrm_q[k+1] <= shift ? '{zero: nrm_q[k].zero, x: (nrm_q[k].x <<< SH),
                              y: (nrm_q[k].y <<< SH), m: (nrm_q[k].m << SH),
                              z: nrm_q[k].z}
                          : nrm_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    rot_q[0] <= '{zero: nrm_q[NORM_STEPS].zero, x: CX_W'(nrm_q[NORM_STEPS].x),
                  y: CX_W'(nrm_q[NORM_STEPS].y), z: nrm_q[NORM_STEPS].z};
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ANG = atan_step(i);
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;
    logic                   up;
    assign dx = rot_q[i].y >>> i;
    assign dy = rot_q[i].x >>> i;
    assign up = !rot_q[i].y[CX_W-1] && (rot_q[i].y != '0);
    always_ff @(posedge clk_i) begin
      rot_q[i+1] <= up ? '{zero: rot_q[i].zero, x: (rot_q[i].x + dx),
                           y: (rot_q[i].y - dy), z: (rot_q[i].z + ANG)}
                       : '{zero: rot_q[i].zero, x: (rot_q[i].x - dx),
                           y: (rot_q[i].y + dy), z: (rot_q[i].z - ANG)};
    end
  end

  assign z_o = rot_q[STEPS].zero ? '0 : rot_q[STEPS].z;

endmodule

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
// Quaternion to Euler angles (YXZ) converter, fully pipelined.
// The pipeline holds the input registers, 2 product and sum stages, 65 divider and
// square-root stages, 8 + CORDIC_STEPS CORDIC stages and the output stage.
// Throughput: one item per cycle; busy is always low and results are single-cycle strobes.
// Reset (rst_ni, asynchronous, active low) clears all valid bits and loads the threshold 32735.
`include "assert_macros.svh"
module quaternion_to_euler_angles
  import qte_pkg::*;
#(
  parameter int COMPONENT_WIDTH = COMP_W_DEF,
  parameter int CORDIC_STEPS    = STEPS_DEF
)(
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_w_i,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_z_i,
  output logic                              done_o,
  output logic signed [ANG_W-1:0]           angle_x_o,
  output logic signed [ANG_W-1:0]           angle_y_o,
  output logic signed [ANG_W-1:0]           angle_z_o,
  output logic [1:0]                        pole_case_o,
  output logic                              zero_norm_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [CFG_ADDR_W-1:0]             paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int CORDIC_LAT  = 2 + NORM_STEPS + CORDIC_STEPS;
  localparam int SIDE_DLY    = ASIN_LAT - 2;
  localparam int ACC_TO_DONE = ASIN_LAT + CORDIC_LAT + 4;

  function automatic logic signed [ANG_W-1:0] to_q13(input logic signed [EXT_W-1:0] a);
    logic signed [EXT_W-1:0] r;
    r = (a + EXT_W'(Q13_HALF)) >>> Q13_SHIFT;
    if (r > EXT_W'(ANG_MAX)) begin
      return ANG_W'(ANG_MAX);
    end
    if (r < EXT_W'(ANG_MIN)) begin
      return ANG_W'(ANG_MIN);
    end
    return ANG_W'(r);
  endfunction

  logic [THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && paddr == REG_POLE_THR) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  assign prdata = (paddr == REG_POLE_THR) ? 32'(thr_q) : '0;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  logic signed [COMPONENT_WIDTH-1:0] raw  [4];
  logic signed [Q_W-1:0]             comp [4];

  assign raw[0] = quat_w_i;
  assign raw[1] = quat_x_i;
  assign raw[2] = quat_y_i;
  assign raw[3] = quat_z_i;

  for (genvar c = 0; c < 4; c++) begin : g_comp
    if (COMPONENT_WIDTH > Q_W) begin : g_wide
      assign comp[c] = Q_W'(raw[c] >>> (COMPONENT_WIDTH - Q_W));
    end else if (COMPONENT_WIDTH < Q_W) begin : g_narrow
      assign comp[c] = {raw[c], {(Q_W - COMPONENT_WIDTH){1'b0}}};
    end else begin : g_same
      assign comp[c] = raw[c];
    end
  end

  logic [4:0] v_q;
  logic signed [Q_W-1:0] w1_q, x1_q, y1_q, z1_q;
  logic signed [Q_W-1:0] x2_q, y2_q, x3_q, y3_q;
  logic signed [PROD_W-1:0] p_ww_q, p_xx_q, p_yy_q, p_zz_q, p_wx_q;
  logic signed [PROD_W-1:0] p_yz_q, p_wy_q, p_zx_q, p_wz_q, p_xy_q;
  logic [UNIT_W-1:0] unit_d, unit3_q;
  logic signed [ARG_W-1:0] d3_q, yn3_q, yd3_q, zn3_q, zd3_q;
  logic signed [CMP_W-1:0] lhs4_q, rhs4_q;
  side_t side4_q, side5_q;
  logic [1:0] pole_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], start && !busy};
    end
  end

  assign unit_d = UNIT_W'(p_ww_q) + UNIT_W'(p_xx_q) + UNIT_W'(p_yy_q) + UNIT_W'(p_zz_q);

  always_comb begin
    pole_d = POLE_NONE;
    if (lhs4_q > rhs4_q) begin
      pole_d = POLE_NORTH;
    end else if (lhs4_q < -rhs4_q) begin
      pole_d = POLE_SOUTH;
    end
  end

  always_ff @(posedge clk_i) begin
    w1_q <= comp[0];
    x1_q <= comp[1];
    y1_q <= comp[2];
    z1_q <= comp[3];

    p_ww_q <= w1_q * w1_q;
    p_xx_q <= x1_q * x1_q;
    p_yy_q <= y1_q * y1_q;
    p_zz_q <= z1_q * z1_q;
    p_wx_q <= w1_q * x1_q;
    p_yz_q <= y1_q * z1_q;
    p_wy_q <= w1_q * y1_q;
    p_zx_q <= z1_q * x1_q;
    p_wz_q <= w1_q * z1_q;
    p_xy_q <= x1_q * y1_q;
    x2_q   <= x1_q;
    y2_q   <= y1_q;

    unit3_q <= unit_d;
    d3_q    <= ARG_W'(p_wx_q) - ARG_W'(p_yz_q);
    yn3_q   <= (ARG_W'(p_wy_q) + ARG_W'(p_zx_q)) <<< 1;
    yd3_q   <= $signed(ARG_W'(unit_d)) - ((ARG_W'(p_xx_q) + ARG_W'(p_yy_q)) <<< 1);
    zn3_q   <= (ARG_W'(p_wz_q) + ARG_W'(p_xy_q)) <<< 1;
    zd3_q   <= $signed(ARG_W'(unit_d)) - ((ARG_W'(p_zz_q) + ARG_W'(p_xx_q)) <<< 1);
    x3_q    <= x2_q;
    y3_q    <= y2_q;

    lhs4_q  <= CMP_W'(d3_q) <<< 16;
    rhs4_q  <= $signed(CMP_W'(thr_q) * CMP_W'(unit3_q));
    side4_q <= '{pole: POLE_NONE, zero: (unit3_q == '0), qx: x3_q, qy: y3_q,
                 yn: yn3_q, yd: yd3_q, zn: zn3_q, zd: zd3_q};

    side5_q <= '{pole: (side4_q.zero ? POLE_NONE : pole_d), zero: side4_q.zero,
                 qx: side4_q.qx, qy: side4_q.qy, yn: side4_q.yn, yd: side4_q.yd,
                 zn: side4_q.zn, zd: side4_q.zd};
  end

  logic signed [S_W-1:0] sin_a;
  logic [C_W-1:0]        cos_a;

  qte_asin_arg u_asin_arg (
    .clk_i (clk_i),
    .num_i (d3_q <<< 1),
    .den_i (unit3_q),
    .sin_o (sin_a),
    .cos_o (cos_a)
  );

  side_t side_q [SIDE_DLY];
  logic [SIDE_DLY-1:0] side_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_v_q <= '0;
    end else begin
      side_v_q <= {side_v_q[SIDE_DLY-2:0], v_q[4]};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side5_q;
    for (int k = 1; k < SIDE_DLY; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  side_t side_o;
  logic signed [CIN_W-1:0] ca_y, ca_x;
  logic signed [ZW-1:0]    za, zy, zz;

  assign side_o = side_q[SIDE_DLY-1];
  assign ca_y   = (side_o.pole != POLE_NONE) ? CIN_W'(side_o.qy) : CIN_W'(sin_a);
  assign ca_x   = (side_o.pole != POLE_NONE) ? CIN_W'(side_o.qx) : $signed(CIN_W'(cos_a));

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_a (
    .clk_i (clk_i),
    .y_i   (ca_y),
    .x_i   (ca_x),
    .z_o   (za)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_y (
    .clk_i (clk_i),
    .y_i   (CIN_W'(side_o.yn)),
    .x_i   (CIN_W'(side_o.yd)),
    .z_o   (zy)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_z (
    .clk_i (clk_i),
    .y_i   (CIN_W'(side_o.zn)),
    .x_i   (CIN_W'(side_o.zd)),
    .z_o   (zz)
  );

  tail_t tail_q [CORDIC_LAT];
  logic [CORDIC_LAT-1:0] tail_v_q;
  tail_t tail_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_v_q <= '0;
    end else begin
      tail_v_q <= {tail_v_q[CORDIC_LAT-2:0], side_v_q[SIDE_DLY-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    tail_q[0] <= '{pole: side_o.pole, zero: side_o.zero};
    for (int k = 1; k < CORDIC_LAT; k++) begin
      tail_q[k] <= tail_q[k-1];
    end
  end

  assign tail_o = tail_q[CORDIC_LAT-1];

  logic signed [EXT_W-1:0] ax_e, ay_e, az_e;

  always_comb begin
    ax_e = EXT_W'(za);
    ay_e = EXT_W'(zy);
    az_e = EXT_W'(zz);
    case (tail_o.pole)
      POLE_NORTH: begin
        ax_e = EXT_W'(HALF_PI_Q30);
        ay_e = EXT_W'(za) <<< 1;
        az_e = '0;
      end
      POLE_SOUTH: begin
        ax_e = -EXT_W'(HALF_PI_Q30);
        ay_e = -(EXT_W'(za) <<< 1);
        az_e = '0;
      end
      default: begin
      end
    endcase
    if (tail_o.zero) begin
      ax_e = '0;
      ay_e = '0;
      az_e = '0;
    end
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tail_v_q[CORDIC_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_x_o   <= to_q13(ax_e);
    angle_y_o   <= to_q13(ay_e);
    angle_z_o   <= to_q13(az_e);
    pole_case_o <= tail_o.zero ? POLE_NONE : tail_o.pole;
    zero_norm_o <= tail_o.zero;
  end

  assign done_o = done_q;

  logic pole_code_ok, zero_out_ok, north_out_ok;

  assign pole_code_ok = pole_case_o inside {POLE_NONE, POLE_NORTH, POLE_SOUTH};
  assign zero_out_ok  = angle_x_o == '0 && angle_y_o == '0 && angle_z_o == '0 &&
                        pole_case_o == POLE_NONE;
  assign north_out_ok = angle_x_o == HALF_PI_Q13 && angle_z_o == '0 && !zero_norm_o;

  `ASSERT_IMPLIES(a_latency, clk_i, rst_ni, done_o, $past(start && !busy, ACC_TO_DONE))
  `ASSERT_NEVER(a_pole_code, clk_i, rst_ni, done_o && !pole_code_ok)
  `ASSERT_IMPLIES(a_zero_out, clk_i, rst_ni, done_o && zero_norm_o, zero_out_ok)
  `ASSERT_IMPLIES(a_north_out, clk_i, rst_ni, done_o && pole_case_o == POLE_NORTH, north_out_ok)

endmodule

// ===== verif/quaternion_to_euler_angles_test.sv =====
// Self-checking testbench for the quaternion to Euler angles converter
module quaternion_to_euler_angles_test;
  import qte_pkg::*;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [1:0]         pole;
    logic               zero;
  } euler_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               chk;
    logic signed [15:0] ax;
    logic signed [15:0] az;
    logic [1:0]         pole;
    logic               zero;
  } quat_row_t;

  localparam longint PI_Q = 64'sd3373259426;
  localparam longint HPI_Q = 64'sd1686629713;
  localparam longint ONE_Q = 64'sd1 << 30;
  localparam longint FLOOR_Q = 64'sd1 << 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic done_o;
  logic signed [15:0] angle_x_o, angle_y_o, angle_z_o;
  logic [1:0] pole_case_o;
  logic zero_norm_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [15:0] thr_model = THR_RESET;
  euler_t pending_angles[$];
  int errors = 0;
  int sender_idle = 0;

  quat_row_t dir_tab[14] = '{
    '{0, 0, 0, 0, 1, 0, 0, POLE_NONE, 1},
    '{16384, 16384, 0, 0, 1, 12868, 0, POLE_NORTH, 0},
    '{16384, -16384, 0, 0, 1, -12868, 0, POLE_SOUTH, 0},
    '{-32768, -32768, 0, 0, 1, 12868, 0, POLE_NORTH, 0},
    '{16384, 16384, 100, -50, 0, 0, 0, POLE_NONE, 0},
    '{16384, 0, 0, 0, 0, 0, 0, POLE_NONE, 0},
    '{32767, 32767, 32767, 32767, 0, 0, 0, POLE_NONE, 0},
    '{-32768, -32768, -32768, -32768, 0, 0, 0, POLE_NONE, 0},
    '{32767, 0, 0, 0, 0, 0, 0, POLE_NONE, 0},
    '{0, 32767, 0, 0, 0, 0, 0, POLE_NONE, 0},
    '{0, 0, 32767, 0, 0, 0, 0, POLE_NONE, 0},
    '{0, 0, 0, -32768, 0, 0, 0, POLE_NONE, 0},
    '{-32768, 32767, -32768, 32767, 0, 0, 0, POLE_NONE, 0},
    '{0, 0, 1, 1, 0, 0, 0, POLE_NONE, 0}
  };

  quaternion_to_euler_angles dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint arc_step(int i);
    longint tab[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
    if (i < 11) return tab[i];
    if (i <= 30) return 64'sd1 << (30 - i);
    return 0;
  endfunction

  function automatic longint absq(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint atan2_q30(longint y, longint x);
    longint a = 0;
    longint dx, dy;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      a = y >= 0 ? PI_Q : -PI_Q;
      x = -x;
      y = -y;
    end
    while ((absq(x) > absq(y) ? absq(x) : absq(y)) < FLOOR_Q) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; a = a + arc_step(i);
      end else begin
        x = x - dx; y = y + dy; a = a - arc_step(i);
      end
    end
    return a;
  endfunction

  function automatic longint unsigned root_u64(longint unsigned a);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= res + b) begin
        a = a - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] q30_to_q13(longint a);
    longint r;
    r = (a + 65536) >>> 17;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic euler_t euler_of(logic signed [15:0] qw, logic signed [15:0] qx,
                                      logic signed [15:0] qy, logic signed [15:0] qz,
                                      logic [15:0] thr);
    longint w = qw, x = qx, y = qy, z = qz;
    longint n2, lhs, rhs, num, s, ax, ay, az;
    longint unsigned ms, c;
    euler_t r;
    n2 = w * w + x * x + y * y + z * z;
    r = '0;
    if (n2 == 0) begin
      r.zero = 1'b1;
      return r;
    end
    ax = 0; ay = 0; az = 0;
    lhs = (x * w - y * z) * 65536;
    rhs = longint'(thr) * n2;
    r.pole = POLE_NONE;
    if (lhs > rhs) begin
      r.pole = POLE_NORTH;
      ax = HPI_Q;
      ay = 2 * atan2_q30(y, x);
    end else if (lhs < -rhs) begin
      r.pole = POLE_SOUTH;
      ax = -HPI_Q;
      ay = -2 * atan2_q30(y, x);
    end else begin
      num = 2 * (w * x - y * z);
      s = (num * ONE_Q) / n2;
      if (s > ONE_Q) s = ONE_Q;
      if (s < -ONE_Q) s = -ONE_Q;
      ms = absq(s);
      c = root_u64((64'd1 << 60) - ms * ms);
      ax = atan2_q30(s, longint'(c));
      ay = atan2_q30(2 * (w * y + z * x), n2 - 2 * (x * x + y * y));
      az = atan2_q30(2 * (w * z + x * y), n2 - 2 * (z * z + x * x));
    end
    r.ax = q30_to_q13(ax);
    r.ay = q30_to_q13(ay);
    r.az = q30_to_q13(az);
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    euler_t want;
    if (rst_ni && start && !busy)
      pending_angles.push_back(euler_of(quat_w_i, quat_x_i, quat_y_i, quat_z_i, thr_model));
    if (rst_ni && done_o) begin
      if (pending_angles.size() == 0) begin
        report("unexpected item", 1, 0);
      end else begin
        want = pending_angles.pop_front();
        if (angle_x_o !== want.ax) report("angle_x", angle_x_o, want.ax);
        if (angle_y_o !== want.ay) report("angle_y", angle_y_o, want.ay);
        if (angle_z_o !== want.az) report("angle_z", angle_z_o, want.az);
        if (pole_case_o !== want.pole) report("pole_case", pole_case_o, want.pole);
        if (zero_norm_o !== want.zero) report("zero_norm", zero_norm_o, want.zero);
      end
    end
  end

  task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    while ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    quat_w_i <= w;
    quat_x_i <= x;
    quat_y_i <= y;
    quat_z_i <= z;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_angles.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_POLE_THR;
    pwdata <= {16'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    thr_model = v;
  endtask

  function automatic logic signed [15:0] rand_comp(int kind);
    case (kind)
      0: return $signed(16'($urandom_range(65535)));
      1: return $signed(16'($urandom_range(16))) - 16'sd8;
      2: return $urandom_range(1) ? 16'sd32767 : -16'sd32768;
      default: return $signed(16'($urandom_range(4000))) - 16'sd2000;
    endcase
  endfunction

  task automatic send_random;
    logic signed [15:0] w, x, y, z;
    int kind;
    kind = $urandom_range(9);
    if (kind < 4) begin
      w = rand_comp(0); x = rand_comp(0); y = rand_comp(0); z = rand_comp(0);
    end else if (kind < 6) begin
      w = rand_comp(1); x = rand_comp(1); y = rand_comp(1); z = rand_comp(1);
    end else if (kind < 8) begin
      w = rand_comp(0);
      x = $urandom_range(1) ? w + rand_comp(3) : -w + rand_comp(3);
      y = rand_comp(3); z = rand_comp(3);
    end else if (kind == 8) begin
      w = rand_comp(2); x = rand_comp(2); y = rand_comp(2); z = rand_comp(2);
    end else begin
      w = $urandom_range(1) ? rand_comp(0) : 16'sd0;
      x = $urandom_range(1) ? rand_comp(0) : 16'sd0;
      y = $urandom_range(1) ? rand_comp(0) : 16'sd0;
      z = $urandom_range(1) ? rand_comp(0) : 16'sd0;
    end
    send_quat(w, x, y, z);
  endtask

  initial begin
    euler_t got;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].chk) begin
        got = euler_of(dir_tab[i].w, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, thr_model);
        if (got.ax !== dir_tab[i].ax) report("row angle_x", got.ax, dir_tab[i].ax);
        if (got.az !== dir_tab[i].az) report("row angle_z", got.az, dir_tab[i].az);
        if (got.pole !== dir_tab[i].pole) report("row pole_case", got.pole, dir_tab[i].pole);
        if (got.zero !== dir_tab[i].zero) report("row zero_norm", got.zero, dir_tab[i].zero);
      end
      send_quat(dir_tab[i].w, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z);
    end
    drain();
    write_threshold(16'hFFFF);
    sender_idle = 19;
    repeat (500) send_random();
    drain();
    write_threshold(16'h0000);
    sender_idle = 46;
    repeat (500) send_random();
    drain();
    write_threshold(16'($urandom_range(65535)));
    sender_idle = 0;
    repeat (300) send_random();
    drain();
    write_threshold(THR_RESET);
    repeat (250) send_random();
    drain();
    repeat (120) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== quaternion_to_euler_angles.f =====
+incdir+hw/rtl
hw/rtl/qte_pkg.sv
hw/rtl/qte_asin_arg.sv
hw/rtl/qte_cordic.sv
hw/rtl/quaternion_to_euler_angles.sv
verif/quaternion_to_euler_angles_test.sv
